[hdl/rmd_pkg.sv]
package rmd_pkg;

    // message layout
    localparam int MAGIC_LEN      = 6;
    localparam int HEADER_BYTES   = MAGIC_LEN + 1 + 12;
    localparam int WORD_BYTES     = 4;
    localparam int KEY_BYTES_DEF  = 32;
    localparam int HEX_ALPHA_BASE = 10;

    // register map
    localparam int          PADDR_W   = 3;
    localparam logic [2:0]  ADDR_HEX  = 3'd0;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_TYPE   = 3'd1,
        PH_ROUND  = 3'd2,
        PH_SIGNER = 3'd3,
        PH_COUNT  = 3'd4,
        PH_AUX    = 3'd5,
        PH_KEY    = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_TYPE   = 3'd1,
        KIND_ROUND  = 3'd2,
        KIND_SIGNER = 3'd3,
        KIND_COUNT  = 3'd4,
        KIND_AUX    = 3'd5,
        KIND_KEY    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_TRAILING  = 3'd3,
        ST_BAD_HEX   = 3'd4,
        ST_ODD_HEX   = 3'd5
    } t_status;

    // first parse fault sticks
    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_MAGIC = 2'd1,
        FAULT_TRAIL = 2'd3
    } t_fault;

    // expected magic byte at a position
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h43;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h4D;
            3'd3:    b = 8'h4D;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // ascii hex character to {bad, nibble}; bad characters give nibble zero
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h61 + 8'(HEX_ALPHA_BASE))};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h41 + 8'(HEX_ALPHA_BASE))};
        end else begin
            r = 5'b10000;
        end
        return r;
    endfunction

endpackage

[hdl/round_message_deframer_core.sv]
// a word's result, if it gives one, is registered and shows in the cycle after the word is accepted
// throughput: one word per cycle; the single output register holds the result and
// a new word is taken whenever that register is empty or being drained
// reset (synchronous, active low) clears the parser state, the output valid flag
// and the hex mode register; the parser also returns to reset after each last word
module round_message_deframer_core
    import rmd_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data,
    input  logic               i_last,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_value,
    output logic [31:0]        o_entry_index,
    output logic [4:0]         o_key_byte_index,
    output logic               o_message_end,
    output logic [2:0]         o_status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KEY_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int POS_W = (KEY_W > 3) ? KEY_W : 3;

    // parser state
    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [23:0]        r_word, n_word;
    logic [31:0]        r_expected, n_expected;
    logic [31:0]        r_entry, n_entry;
    logic [3:0]         r_high, n_high;
    logic               r_half, n_half;
    logic               r_hex_fault, n_hex_fault;
    t_fault             r_fault, n_fault;
    logic               r_hex_input;

    // output register
    logic               r_out_valid, n_out_valid;
    t_kind              r_kind, n_kind;
    logic [31:0]        r_value, n_value;
    logic [31:0]        r_eidx, n_eidx;
    logic [4:0]         r_kidx, n_kidx;
    logic               r_end, n_end;
    t_status            r_status, n_status;

    logic               in_acc;
    logic [4:0]         v_nib;
    logic [7:0]         v_byte;
    logic               v_have;
    logic               v_emit;
    logic [31:0]        v_full;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {31'd0, r_hex_input};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_input <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_HEX) begin
            r_hex_input <= pwdata[0];
        end
    end

    // byte decode, field parse and verdict
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_word      = r_word;
        n_expected  = r_expected;
        n_entry     = r_entry;
        n_high      = r_high;
        n_half      = r_half;
        n_hex_fault = r_hex_fault;
        n_fault     = r_fault;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_value     = r_value;
        n_eidx      = r_eidx;
        n_kidx      = r_kidx;
        n_end       = r_end;
        n_status    = r_status;
        v_nib       = hex_nibble(i_data);
        v_byte      = i_data;
        v_have      = 1'b0;
        v_emit      = 1'b0;
        v_full      = {i_data, r_word};

        if (in_acc) begin
            n_kind   = KIND_NONE;
            n_value  = 32'd0;
            n_eidx   = 32'd0;
            n_kidx   = 5'd0;
            n_status = ST_OK;

            // hex pairing
            if (r_hex_input) begin
                if (v_nib[4]) begin
                    n_hex_fault = 1'b1;
                end
                if (!r_half) begin
                    n_high = v_nib[3:0];
                    n_half = 1'b1;
                end else begin
                    v_byte = {r_high, v_nib[3:0]};
                    v_full = {v_byte, r_word};
                    n_half = 1'b0;
                    v_have = 1'b1;
                end
            end else begin
                n_half = 1'b0;
                v_have = 1'b1;
            end

            // field state machine
            if (v_have) begin
                case (r_phase)
                    PH_MAGIC: begin
                        if (v_byte != magic_byte(r_pos[2:0]) && r_fault == FAULT_NONE) begin
                            n_fault = FAULT_MAGIC;
                        end
                        if (r_pos == POS_W'(MAGIC_LEN - 1)) begin
                            n_pos   = '0;
                            n_phase = PH_TYPE;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                    PH_TYPE: begin
                        v_emit  = 1'b1;
                        n_kind  = KIND_TYPE;
                        n_value = {24'd0, v_byte};
                        n_phase = PH_ROUND;
                    end
                    PH_ROUND, PH_SIGNER, PH_COUNT, PH_AUX: begin
                        if (r_pos < POS_W'(WORD_BYTES - 1)) begin
                            case (r_pos[1:0])
                                2'd0:    n_word[7:0]   = v_byte;
                                2'd1:    n_word[15:8]  = v_byte;
                                default: n_word[23:16] = v_byte;
                            endcase
                            n_pos = r_pos + POS_W'(1);
                        end else begin
                            v_emit  = 1'b1;
                            n_word  = 24'd0;
                            n_pos   = '0;
                            n_value = v_full;
                            case (r_phase)
                                PH_ROUND: begin
                                    n_kind  = KIND_ROUND;
                                    n_phase = PH_SIGNER;
                                end
                                PH_SIGNER: begin
                                    n_kind  = KIND_SIGNER;
                                    n_phase = PH_COUNT;
                                end
                                PH_COUNT: begin
                                    n_kind     = KIND_COUNT;
                                    n_expected = v_full;
                                    n_entry    = 32'd0;
                                    n_phase    = (v_full == 32'd0) ? PH_DONE : PH_AUX;
                                end
                                default: begin
                                    n_kind  = KIND_AUX;
                                    n_eidx  = r_entry;
                                    n_phase = PH_KEY;
                                end
                            endcase
                        end
                    end
                    PH_KEY: begin
                        v_emit  = 1'b1;
                        n_kind  = KIND_KEY;
                        n_value = {24'd0, v_byte};
                        n_eidx  = r_entry;
                        n_kidx  = 5'(r_pos);
                        if (r_pos == POS_W'(KEY_BYTES - 1)) begin
                            n_pos   = '0;
                            n_entry = r_entry + 32'd1;
                            n_phase = (r_entry + 32'd1 == r_expected) ? PH_DONE : PH_AUX;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                    default: begin
                        if (r_fault == FAULT_NONE) begin
                            n_fault = FAULT_TRAIL;
                        end
                    end
                endcase
            end

            // verdict on the last word, then back to reset
            n_out_valid = v_emit || i_last;
            n_end       = i_last;
            if (i_last) begin
                if (r_hex_input && n_half) begin
                    n_status = ST_ODD_HEX;
                end else if (n_hex_fault) begin
                    n_status = ST_BAD_HEX;
                end else if (n_fault == FAULT_MAGIC) begin
                    n_status = ST_BAD_MAGIC;
                end else if (n_phase != PH_DONE) begin
                    n_status = ST_TRUNC;
                end else if (n_fault == FAULT_TRAIL) begin
                    n_status = ST_TRAILING;
                end else begin
                    n_status = ST_OK;
                end
                n_phase     = PH_MAGIC;
                n_pos       = '0;
                n_word      = 24'd0;
                n_expected  = 32'd0;
                n_entry     = 32'd0;
                n_high      = 4'd0;
                n_half      = 1'b0;
                n_hex_fault = 1'b0;
                n_fault     = FAULT_NONE;
            end
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_pos       <= '0;
            r_word      <= 24'd0;
            r_expected  <= 32'd0;
            r_entry     <= 32'd0;
            r_high      <= 4'd0;
            r_half      <= 1'b0;
            r_hex_fault <= 1'b0;
            r_fault     <= FAULT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_word      <= n_word;
            r_expected  <= n_expected;
            r_entry     <= n_entry;
            r_high      <= n_high;
            r_half      <= n_half;
            r_hex_fault <= n_hex_fault;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_eidx   <= n_eidx;
        r_kidx   <= n_kidx;
        r_end    <= n_end;
        r_status <= n_status;
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_value          = r_value;
    assign o_entry_index    = r_eidx;
    assign o_key_byte_index = r_kidx;
    assign o_message_end    = r_end;
    assign o_status         = r_status;

    // done only once every announced entry has been seen
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> r_entry == r_expected)
        else $error("done phase with entry count mismatch");

    // the last word returns the parser to its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last |=> r_phase == PH_MAGIC && !r_half && !r_hex_fault
                             && r_fault == FAULT_NONE)
        else $error("parser not cleared after last word");

    // an error verdict only rides on the message end
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_message_end)
        else $error("status without message end");

    // a key byte result carries an in-range key position
    a_key_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_KEY |-> int'(r_pos) < KEY_BYTES)
        else $error("key position out of range");

endmodule
